>>> sv/olrb_pkg.sv
// Package for the overwriting log ring buffer.
// Holds the opcode and state encodings and the controller/datapath structs.
// No dependencies; used by every other file of the block.
package olrb_pkg;

    typedef enum logic [1:0] {
        OP_PUT     = 2'd0,
        OP_CONSUME = 2'd1,
        OP_READ    = 2'd2,
        OP_REWIND  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_FETCH  = 2'd1,
        ST_RESULT = 2'd2
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;    // a beat is accepted this cycle
        logic capture;  // store read data into the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_fetch;  // the accepted beat returns a byte from the store
    } dp_status_t;

endpackage

>>> sv/olrb_ctrl.sv
// Controller state machine of the overwriting log ring buffer.
// Depends on olrb_pkg for the state encoding and the command/status structs.
module olrb_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    input  olrb_pkg::dp_status_t    status,
    output olrb_pkg::ctrl_cmd_t     cmd
);

    olrb_pkg::state_t state_reg;
    olrb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.start   = 1'b0;
        cmd.capture = 1'b0;
        state_next  = state_reg;
        unique case (state_reg)
            olrb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            olrb_pkg::ST_FETCH:
            begin
                // The store's registered read data is valid now.
                cmd.capture = 1'b1;
                state_next  = olrb_pkg::ST_RESULT;
            end
            olrb_pkg::ST_RESULT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                if (out_ready)
                begin
                    state_next = olrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = olrb_pkg::ST_IDLE;
            end
        endcase

        cmd.start = in_valid && in_ready;
        if (cmd.start)
        begin
            state_next = status.need_fetch ? olrb_pkg::ST_FETCH : olrb_pkg::ST_RESULT;
        end
    end

endmodule

>>> sv/olrb_datapath.sv
// Datapath of the overwriting log ring buffer: pointers, byte store, result registers.
// Depends on olrb_pkg for the opcode encoding and the command/status structs.
module olrb_datapath
#(
    parameter int DEPTH = 128
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              opcode,
    input  logic [7:0]              write_byte,
    input  olrb_pkg::ctrl_cmd_t     cmd,
    output olrb_pkg::dp_status_t    status,
    output logic [7:0]              read_byte,
    output logic                    byte_valid,
    output logic                    dropped_oldest,
    output logic                    buffer_empty,
    output logic                    reader_caught_up
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        logic [PW-1:0] last;
        last = PW'(DEPTH - 1);
        return (p == last) ? '0 : p + PW'(1);
    endfunction

    logic [PW-1:0]      wp_reg;
    logic [PW-1:0]      cp_reg;
    logic [PW-1:0]      rc_reg;
    logic [PW-1:0]      wp_next;
    logic [PW-1:0]      cp_next;
    logic [PW-1:0]      rc_next;
    logic [PW-1:0]      raddr;
    logic               wr_en;
    logic               dropped_next;
    logic [7:0]         byte_store_reg [DEPTH];
    logic [7:0]         rdata_reg;
    logic [7:0]         read_byte_reg;
    logic               byte_valid_reg;
    logic               dropped_reg;
    logic               empty_reg;
    logic               caught_reg;
    olrb_pkg::opcode_t  op;

    assign op = olrb_pkg::opcode_t'(opcode);

    always_comb
    begin
        wp_next           = wp_reg;
        cp_next           = cp_reg;
        rc_next           = rc_reg;
        raddr             = cp_reg;
        wr_en             = 1'b0;
        dropped_next      = 1'b0;
        status.need_fetch = 1'b0;
        case (op)
            olrb_pkg::OP_PUT:
            begin
                wr_en   = 1'b1;
                wp_next = ring_next(wp_reg);
                // Full: drop the oldest byte and park the reader on the new oldest.
                if (ring_next(wp_reg) == cp_reg)
                begin
                    cp_next      = ring_next(cp_reg);
                    rc_next      = ring_next(cp_reg);
                    dropped_next = 1'b1;
                end
            end
            olrb_pkg::OP_CONSUME:
            begin
                raddr = cp_reg;
                if (wp_reg != cp_reg)
                begin
                    cp_next           = ring_next(cp_reg);
                    status.need_fetch = 1'b1;
                end
            end
            olrb_pkg::OP_READ:
            begin
                raddr = rc_reg;
                if (wp_reg != rc_reg)
                begin
                    rc_next           = ring_next(rc_reg);
                    status.need_fetch = 1'b1;
                end
            end
            olrb_pkg::OP_REWIND:
            begin
                rc_next = cp_reg;
            end
            default:
            begin
                rc_next = rc_reg;
            end
        endcase
    end

    // Byte store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.start && wr_en)
        begin
            byte_store_reg[wp_reg] <= write_byte;
        end
        if (cmd.start && status.need_fetch)
        begin
            rdata_reg <= byte_store_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            cp_reg         <= '0;
            rc_reg         <= '0;
            byte_valid_reg <= 1'b0;
            dropped_reg    <= 1'b0;
            empty_reg      <= 1'b1;
            caught_reg     <= 1'b1;
        end
        else if (cmd.start)
        begin
            wp_reg         <= wp_next;
            cp_reg         <= cp_next;
            rc_reg         <= rc_next;
            byte_valid_reg <= status.need_fetch;
            dropped_reg    <= dropped_next;
            empty_reg      <= (wp_next == cp_next);
            caught_reg     <= (rc_next == wp_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            read_byte_reg <= rdata_reg;
        end
        else if (cmd.start)
        begin
            read_byte_reg <= '0;
        end
    end

    assign read_byte        = read_byte_reg;
    assign byte_valid       = byte_valid_reg;
    assign dropped_oldest   = dropped_reg;
    assign buffer_empty     = empty_reg;
    assign reader_caught_up = caught_reg;

endmodule

>>> sv/overwriting_log_ring_buffer.sv
// Top level of the overwriting log ring buffer: controller plus datapath.
// Depends on olrb_pkg, olrb_ctrl and olrb_datapath.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------------------------
//  input    | in_valid / in_ready  | opcode, write_byte
//  output   | out_valid/ out_ready | read_byte, byte_valid, dropped_oldest,
//           |                      | buffer_empty, reader_caught_up
//
// A put or rewind result is presented in the cycle after its beat is accepted; a consume
// or read that returns a byte passes through ST_FETCH, for the store's registered read.
// A new beat is accepted in the same cycle that the pending result is taken, so puts and
// rewinds stream at one beat per cycle while out_ready is high; none enters in ST_FETCH.
// Reset clears the three pointers, so the buffer starts empty; the store is not cleared.
// A stall on the output holds the result register and keeps in_ready low.
module overwriting_log_ring_buffer
#(
    parameter int DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_byte,
    output logic        byte_valid,
    output logic        dropped_oldest,
    output logic        buffer_empty,
    output logic        reader_caught_up
);

    olrb_pkg::ctrl_cmd_t  cmd;
    olrb_pkg::dp_status_t status;

    // The controller sequences accept, store read and result hand-off.
    olrb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath owns the pointers, the byte store and the result registers.
    olrb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .opcode           (opcode),
        .write_byte       (write_byte),
        .cmd              (cmd),
        .status           (status),
        .read_byte        (read_byte),
        .byte_valid       (byte_valid),
        .dropped_oldest   (dropped_oldest),
        .buffer_empty     (buffer_empty),
        .reader_caught_up (reader_caught_up)
    );

    // A put never waits on the store read, so its result shows in the next cycle.
    a_put_result_next: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == olrb_pkg::OP_PUT) |=> (out_valid && !byte_valid))
        else $error("put result not presented in the following cycle");

    // After a rewind the reader sits on the oldest byte.
    a_rewind_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && opcode == olrb_pkg::OP_REWIND) |=>
        (out_valid && reader_caught_up == buffer_empty))
        else $error("rewind left the reader away from the oldest byte");

    // A drop happens only on a full buffer, which stays nonempty with the reader behind.
    a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped_oldest) |-> (!buffer_empty && !reader_caught_up && !byte_valid))
        else $error("inconsistent flags after an overwrite");

    // No byte returned means the byte field reads zero.
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> (read_byte == 8'd0))
        else $error("nonzero byte without byte_valid");

endmodule
